// ===== sv/der_pkg.sv =====
// ----------------------------------------------------------------------------
// der_pkg
// Shared types and constants for the dedup entry relocator.
// ----------------------------------------------------------------------------
package der_pkg;

   // id table geometry (home slot is the low TBL_AW bits of the id)
   localparam int TBL_AW        = 16;
   localparam int TABLE_ENTRIES = 1 << TBL_AW;
   localparam int MAX_PROBES    = 8;
   localparam int PROBE_CW      = $clog2(MAX_PROBES + 1);

   // field widths
   localparam int ID_W     = 32;
   localparam int SIZE_W   = 27;
   localparam int OFS_W    = 32;
   localparam int PACK_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int START_W  = 16;
   localparam int SLOT_W   = ID_W + 1;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [OFS_W-1:0]   OFS_MAX   = {OFS_W{1'b1}};

   localparam logic [OFS_W-1:0]   SPLIT_RESET = 32'd1900000000;
   localparam logic [START_W-1:0] START_RESET = 16'd32;

   // configuration register indexes
   localparam logic CSR_SPLIT_LIMIT  = 1'b0;
   localparam logic CSR_START_OFFSET = 1'b1;

   // input command codes
   localparam logic CMD_ENTRY  = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic clear;       // write an empty slot at the sweep address, advance it
      logic accept;      // capture the request, read the home slot
      logic probe;       // advance to the next slot and read it
      logic insert;      // store the id in the current slot, mark kept
      logic mark_full;   // no free slot found
      logic place;       // assign offset and advance pack state
      logic emit;        // load the result register and commit pack closing
   } der_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;  // sweep at last slot
      logic slot_valid;
      logic slot_match;
      logic last_probe;
      logic out_free;    // result register empty or being taken
   } der_status_type;

endpackage

// ===== sv/der_ctrl.sv =====
// ----------------------------------------------------------------------------
// der_ctrl
// Sequencer: table clear sweep, slot probing, placement and result issue.
// ----------------------------------------------------------------------------
module der_ctrl
   import der_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  der_status_type status,
   output der_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_CHECK = 5'b00100,
      S_PLACE = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_tuser == CMD_FINISH) ? S_EMIT : S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.slot_valid) begin
               cmd.insert = 1'b1;
               state_in   = S_PLACE;
            end else if (status.slot_match) begin
               state_in = S_EMIT;
            end else if (status.last_probe) begin
               cmd.mark_full = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.probe = 1'b1;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register can take the transfer
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/der_datapath.sv =====
// ----------------------------------------------------------------------------
// der_datapath
// Id table memory, probe address, pack state, settings and result register.
// ----------------------------------------------------------------------------
module der_datapath
   import der_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  der_cmd_type           cmd,
   output der_status_type        status,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_KEPT = 2'd1,
      OUT_FULL = 2'd2,
      OUT_FIN  = 2'd3
   } outcome_type;

   // id table: valid bit on top of the id
   logic [SLOT_W-1:0] mem [TABLE_ENTRIES];
   logic [SLOT_W-1:0] rd_data_ff;
   logic [TBL_AW-1:0] rd_addr;
   logic              mem_we;
   logic [TBL_AW-1:0] mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;

   logic [TBL_AW-1:0]   clr_addr_ff;
   logic [TBL_AW-1:0]   probe_addr_ff;
   logic [PROBE_CW-1:0] probe_cnt_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SIZE_W-1:0]   size_ff;
   outcome_type         outcome_ff;

   logic [OFS_W-1:0]   split_limit_ff;
   logic [START_W-1:0] start_offset_ff;

   logic [OFS_W-1:0]   write_offset_ff;
   logic               pack_open_ff;
   logic [PACK_W-1:0]  pack_index_ff;
   logic [COUNT_W-1:0] entries_ff;
   logic [OFS_W-1:0]   offs_ff;

   logic               rsp_valid_ff;
   logic               kept_ff;
   logic [OFS_W-1:0]   new_offset_ff;
   logic [PACK_W-1:0]  pack_number_ff;
   logic               closed_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               full_ff;

   // placement arithmetic
   logic [OFS_W-1:0]   base_ofs;
   logic [OFS_W:0]     sum;
   logic [COUNT_W-1:0] base_cnt;
   logic               over_split;

   // ---- table access
   assign rd_addr   = cmd.accept ? req_tdata[TBL_AW-1:0] : probe_addr_ff + 1'b1;
   assign mem_we    = cmd.clear || cmd.insert;
   assign mem_waddr = cmd.clear ? clr_addr_ff : probe_addr_ff;
   assign mem_wdata = cmd.clear ? '0 : {1'b1, id_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign status.clear_done = (clr_addr_ff == {TBL_AW{1'b1}});
   assign status.slot_valid = rd_data_ff[SLOT_W-1];
   assign status.slot_match = (rd_data_ff[ID_W-1:0] == id_ff);
   assign status.last_probe = (probe_cnt_ff == PROBE_CW'(MAX_PROBES - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // ---- request capture and probing
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff         <= req_tdata[ID_W-1:0];
         size_ff       <= req_tdata[ID_W +: SIZE_W];
         probe_addr_ff <= req_tdata[TBL_AW-1:0];
         probe_cnt_ff  <= '0;
      end else if (cmd.probe) begin
         probe_addr_ff <= probe_addr_ff + 1'b1;
         probe_cnt_ff  <= probe_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outcome_ff <= OUT_NONE;
      end else if (cmd.accept) begin
         outcome_ff <= (req_tuser == CMD_FINISH) ? OUT_FIN : OUT_NONE;
      end else if (cmd.insert) begin
         outcome_ff <= OUT_KEPT;
      end else if (cmd.mark_full) begin
         outcome_ff <= OUT_FULL;
      end
   end

   // ---- settings
   always_ff @(posedge clock) begin
      if (reset) begin
         split_limit_ff  <= SPLIT_RESET;
         start_offset_ff <= START_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SPLIT_LIMIT:  split_limit_ff  <= csr_data;
            CSR_START_OFFSET: start_offset_ff <= csr_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- pack state
   assign base_ofs   = pack_open_ff ? write_offset_ff : OFS_W'(start_offset_ff);
   assign base_cnt   = pack_open_ff ? entries_ff : '0;
   assign sum        = {1'b0, base_ofs} + (OFS_W + 1)'(size_ff);
   assign over_split = (write_offset_ff > split_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff <= '0;
         pack_open_ff    <= 1'b0;
         pack_index_ff   <= '0;
         entries_ff      <= '0;
      end else if (cmd.place) begin
         // open a pack when none is open, then advance offset and count
         write_offset_ff <= sum[OFS_W] ? OFS_MAX : sum[OFS_W-1:0];
         pack_open_ff    <= 1'b1;
         if (!pack_open_ff) begin
            pack_index_ff <= pack_index_ff + 1'b1;
         end
         entries_ff <= (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 1'b1;
      end else if (cmd.emit) begin
         if ((outcome_ff == OUT_FIN) || ((outcome_ff == OUT_KEPT) && over_split)) begin
            pack_open_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         offs_ff <= base_ofs;
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kept_ff        <= 1'b0;
         new_offset_ff  <= '0;
         pack_number_ff <= '0;
         closed_ff      <= 1'b0;
         count_ff       <= '0;
         full_ff        <= 1'b0;
         case (outcome_ff)
            OUT_KEPT: begin
               kept_ff        <= 1'b1;
               new_offset_ff  <= offs_ff;
               pack_number_ff <= pack_index_ff - 1'b1;
               closed_ff      <= over_split;
               count_ff       <= over_split ? entries_ff : '0;
            end
            OUT_FULL: begin
               full_ff <= 1'b1;
            end
            OUT_FIN: begin
               closed_ff <= pack_open_ff;
               count_ff  <= pack_open_ff ? entries_ff : '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, full_ff, count_ff, closed_ff, pack_number_ff,
                        new_offset_ff, kept_ff};

endmodule

// ===== sv/dedup_entry_relocator.sv =====
// ----------------------------------------------------------------------------
// dedup_entry_relocator
// Drops repeated index entries and places new ones into size-limited packs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one index entry or a finish command per transfer; every
//   request yields exactly one transfer on rsp_*. csr_* writes the split
//   limit (index 0) and the start offset of a new pack (index 1); write it
//   only while no request is in flight.
//   Each entry probes up to 8 consecutive slots of a 65536-slot id table
//   in a synchronous memory, one slot read per cycle. A new entry goes
//   from accept through the slot reads, insert and placement to its
//   result; a repeat or a full table skips insert and placement, and a
//   finish goes from accept straight to its result. The next request is
//   taken the cycle after the result is loaded, never while one is open.
//   After reset the block sweeps the table empty, one slot per cycle;
//   req_tready stays low during the sweep, csr writes go on.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next request up to the result and waits there.
// ----------------------------------------------------------------------------
module dedup_entry_relocator
   import der_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] entry_id, [63:32] size_word
   input  logic                  req_tuser,   // [0] command
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] kept, [32:1] new_offset,
                                              // [48:33] pack_number, [49] pack_closed,
                                              // [66:50] closed_count, [67] table_full
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [31:0]           csr_data
);

   der_cmd_type    cmd;
   der_status_type status;

   // settings take a write transfer in any cycle
   assign csr_ready = 1'b1;

   // sequencer: sweep, probe, place, issue
   der_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // id table, pack state and result register
   der_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/sv/tb_dedup_entry_relocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_entry_relocator
// Self-checking bench for the dedup entry relocator: a shadow model of the id
// table, the running offset and the pack bookkeeping predicts every result,
// which is compared field by field as it leaves the block. Directed cases
// cover repeats, probe wrap at the table end, a full probe window, finish
// with and without an open pack, and the split limit and start offset
// extremes. Random phases follow under several register settings, with
// bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_dedup_entry_relocator;
   import der_pkg::*;

   // idle cycles tolerated with no transfer anywhere; the limit also covers
   // the table sweep that runs after reset
   localparam int QUIET_LIMIT = 4 * TABLE_ENTRIES;
   localparam int SETTLE_CYCLES = 16;   // idle wait after the last result, before a register write
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                 kept;
      logic [OFS_W-1:0]     new_offset;
      logic [PACK_W-1:0]    pack_number;
      logic                 pack_closed;
      logic [COUNT_W-1:0]   closed_count;
      logic                 table_full;
   } placement_type;

   typedef enum {LOOKUP_SEARCHING, LOOKUP_INSERTED, LOOKUP_REPEAT} lookup_type;
   typedef enum {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_STARVED} drain_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] entry_id, [63:32] size_word
   logic                  req_tuser = CMD_ENTRY;   // [0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] kept, [32:1] new_offset,
                                       // [48:33] pack_number, [49] pack_closed,
                                       // [66:50] closed_count, [67] table_full
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_SPLIT_LIMIT;
   logic [31:0]           csr_data = '0;

   dedup_entry_relocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // shadow state of the block
   bit                  seen_used [TABLE_ENTRIES];
   logic [ID_W-1:0]     seen_tag  [TABLE_ENTRIES];
   logic [OFS_W-1:0]    run_offset = '0;
   logic                pack_is_open = 1'b0;
   logic [PACK_W-1:0]   packs_opened = '0;
   logic [COUNT_W-1:0]  pack_fill = '0;
   logic [OFS_W-1:0]    cfg_split_limit = SPLIT_RESET;
   logic [START_W-1:0]  cfg_start_offset = START_RESET;

   placement_type       pending_placements [$];
   logic [ID_W-1:0]     known_ids [$];
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   int                  burst_left = 0;
   int                  drain_left = 0;
   drain_mode_type      drain_mode = DRAIN_FREE;

   initial begin
      forever #1 clock = ~clock;
   end

   // Work out the result of one request and advance the shadow state.
   function automatic placement_type place_entry(input logic cmd, input logic [ID_W-1:0] id,
                                                 input logic [31:0] size_word);
      placement_type        res;
      lookup_type           outcome;
      logic [TBL_AW-1:0]    slot;
      logic [OFS_W:0]       sum;
      res = '0;
      if (cmd == CMD_FINISH) begin
         // finish only matters while a pack is open
         if (pack_is_open) begin
            res.pack_closed  = 1'b1;
            res.closed_count = pack_fill;
            pack_is_open     = 1'b0;
         end
      end else begin
         // linear probe from the home slot, wrapping at the table end
         outcome = LOOKUP_SEARCHING;
         slot    = id[TBL_AW-1:0];
         for (int n = 0; n < MAX_PROBES; n++) begin
            if (outcome == LOOKUP_SEARCHING) begin
               if (!seen_used[slot]) begin
                  seen_used[slot] = 1'b1;
                  seen_tag[slot]  = id;
                  outcome         = LOOKUP_INSERTED;
               end else if (seen_tag[slot] == id) begin
                  outcome = LOOKUP_REPEAT;
               end
               slot = slot + 1'b1;
            end
         end
         if (outcome == LOOKUP_SEARCHING) begin
            res.table_full = 1'b1;
         end else if (outcome == LOOKUP_INSERTED) begin
            if (!pack_is_open) begin
               pack_is_open = 1'b1;
               run_offset   = OFS_W'(cfg_start_offset);
               pack_fill    = '0;
               packs_opened = packs_opened + 1'b1;
            end
            res.kept        = 1'b1;
            res.new_offset  = run_offset;
            res.pack_number = packs_opened - 1'b1;
            sum             = {1'b0, run_offset} + (OFS_W + 1)'(size_word[SIZE_W-1:0]);
            run_offset      = sum[OFS_W] ? OFS_MAX : sum[OFS_W-1:0];
            if (pack_fill != COUNT_MAX) pack_fill = pack_fill + 1'b1;
            if (run_offset > cfg_split_limit) begin
               res.pack_closed  = 1'b1;
               res.closed_count = pack_fill;
               pack_is_open     = 1'b0;
            end
         end
      end
      return res;
   endfunction

   // Send one request in the current burst; open a new burst after a random
   // gap when the old one runs out. Record the expected result on transfer.
   task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [31:0] size_word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {size_word, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_placements.push_back(place_entry(cmd, id, size_word));
      if (cmd == CMD_ENTRY) known_ids.push_back(id);
   endtask

   // Drop the request valid, drain every expected result, then let the
   // pipeline go quiet before any register write.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; hold valid high across the pair.
   task automatic program_registers(input logic [OFS_W-1:0] split,
                                    input logic [START_W-1:0] start);
      csr_valid <= 1'b1;
      csr_index <= CSR_SPLIT_LIMIT;
      csr_data  <= split;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_split_limit = split;
      csr_index <= CSR_START_OFFSET;
      csr_data  <= 32'(start);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_start_offset = start;
      csr_valid <= 1'b0;
   endtask

   // Reset register values: empty finish, id zero, repeat, all-ones id and
   // size word (flag bits must be ignored), finish closing, finish idle.
   task automatic test_reset_defaults();
      send_item(CMD_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ENTRY, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_ENTRY, 32'h0000_0000, 32'h0123_4567);
      send_item(CMD_ENTRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_FINISH, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_FINISH, 32'h5A5A_A5A5, 32'hA5A5_5A5A);
      settle_block();
   endtask

   // Ids sharing a home slot near the table end: the chain wraps to slot 0,
   // steps over slots taken above, fills the probe window and overflows.
   // Then repeat the id stored furthest down the chain.
   task automatic test_probe_window();
      for (int k = 1; k <= 8; k++)
         send_item(CMD_ENTRY, {16'(k), 16'hFFFC}, 32'h0000_1000 * k);
      send_item(CMD_ENTRY, {16'd6, 16'hFFFC}, 32'h0000_0001);
      send_item(CMD_ENTRY, 32'hFFFF_FFFF, 32'h0000_0001);
      settle_block();
   endtask

   // Split limit and start offset at their extremes.
   task automatic test_limit_extremes();
      // every placement is past a zero limit when the pack starts high
      program_registers('0, '1);
      send_item(CMD_ENTRY, 32'h1234_0100, 32'h0000_0000);
      send_item(CMD_ENTRY, 32'h1234_0101, 32'hF7FF_FFFF);
      settle_block();
      // zero-size entries at offset zero keep the pack open
      program_registers('0, '0);
      send_item(CMD_ENTRY, 32'h1234_0200, 32'hF800_0000);
      send_item(CMD_ENTRY, 32'h1234_0201, 32'h0000_0000);
      send_item(CMD_ENTRY, 32'h1234_0202, 32'h0000_0001);
      send_item(CMD_FINISH, 32'h1234_0203, 32'h0000_0000);
      settle_block();
      // high limit: four entries of the largest size stay below it, a finish closes the pack
      program_registers(32'hF7FF_FFFF, '0);
      for (int k = 0; k < 4; k++)
         send_item(CMD_ENTRY, 32'h1234_0300 + k, 32'hFFFF_FFFF);
      send_item(CMD_FINISH, 32'h0, 32'h0);
      settle_block();
   endtask

   // Random traffic under one register setting: mostly entries, a mix of
   // fresh ids, repeats and ids crowded into twelve home slots at the table end, plus finishes.
   task automatic test_random_traffic(input int count, input logic [OFS_W-1:0] split,
                                      input logic [START_W-1:0] start);
      logic            cmd;
      logic [ID_W-1:0] id;
      logic [31:0]     size_word;
      int              pick;
      program_registers(split, start);
      for (int i = 0; i < count; i++) begin
         pick      = $urandom_range(0, 99);
         cmd       = (pick < 8) ? CMD_FINISH : CMD_ENTRY;
         id        = $urandom();
         size_word = $urandom();
         if (pick >= 8 && pick < 30 && known_ids.size() != 0)
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
         else if (pick >= 30 && pick < 45)
            id[TBL_AW-1:0] = 16'hFFF4 + 16'($urandom_range(0, 11));
         case ($urandom_range(0, 3))
            0: size_word[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 255));
            1: size_word[SIZE_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
            default: ;
         endcase
         send_item(cmd, id, size_word);
      end
      settle_block();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_probe_window();
      test_limit_extremes();
      test_random_traffic(120, $urandom_range(1 << 20, 1 << 28),
                          START_W'($urandom_range(0, 65535)));
      test_random_traffic(120, SPLIT_RESET, START_RESET);
      test_random_traffic(120, '0, '1);
      test_random_traffic(120, 32'hF7FF_FFFF, '0);
      if (fail_count == 0)
         $display("tb_dedup_entry_relocator: PASS");
      else
         $display("tb_dedup_entry_relocator: FAIL");
      $finish;
   end

   // Receiver: switch between free flow, choppy and starved spells.
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 2));
         drain_left <= $urandom_range(16, 160);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FREE:   rsp_tready <= 1'b1;
         DRAIN_CHOPPY: rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      placement_type got;
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kept         = rsp_tdata[0];
         got.new_offset   = rsp_tdata[32:1];
         got.pack_number  = rsp_tdata[48:33];
         got.pack_closed  = rsp_tdata[49];
         got.closed_count = rsp_tdata[66:50];
         got.table_full   = rsp_tdata[67];
         if (pending_placements.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected: kept=%0d ofs=%0h pack=%0d",
                        $realtime, got.kept, got.new_offset, got.pack_number);
         end else begin
            want = pending_placements.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp kept=%0d ofs=%0h pack=%0d closed=%0d count=%0d full=%0d",
                           $realtime, want.kept, want.new_offset, want.pack_number,
                           want.pack_closed, want.closed_count, want.table_full);
                  $display("%0t:          got kept=%0d ofs=%0h pack=%0d closed=%0d count=%0d full=%0d",
                           $realtime, got.kept, got.new_offset, got.pack_number,
                           got.pack_closed, got.closed_count, got.table_full);
               end
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no transfer on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_dedup_entry_relocator: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
